// ----- hw/rtl/u8u16_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  // Depth of the job queue between the byte front end and the unit back end.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Lead byte classes.
  localparam logic [7:0] LeadMin  = 8'hC2;
  localparam logic [7:0] LeadEnd  = 8'hF5;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;

  // Lead bytes with a narrowed second-byte range.
  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadED = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;

  // Second-byte range bounds.
  localparam logic [7:0] ContMin  = 8'h80;
  localparam logic [7:0] ContMax  = 8'hBF;
  localparam logic [7:0] E0Min    = 8'hA0;
  localparam logic [7:0] EDMax    = 8'h9F;
  localparam logic [7:0] F0Min    = 8'h90;
  localparam logic [7:0] F4Max    = 8'h8F;

  // Surrogate construction.
  localparam logic [15:0] SurrHigh  = 16'hD800;
  localparam logic [15:0] SurrLow   = 16'hDC00;
  localparam logic [20:0] SuppBase  = 21'h010000;

  // One queued job: a single code unit, or a surrogate pair.
  typedef struct packed {
    logic        pair;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
  } job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/u8u16_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte channel: one UTF-8 byte per transaction.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/u8u16_unit_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Unit channel: one UTF-16 code unit per transaction.
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/utf8_to_utf16_decoder_unit.sv -----
// UTF-8 to UTF-16 transcoder.
// in_byte_i takes one UTF-8 byte per transaction with an end-of-text flag;
// out_unit_o gives UTF-16 code units, with last_of_run set on the final unit
// that a byte produces. ASCII bytes pass through, multi-byte sequences give
// one unit (or a surrogate pair for four bytes) when their last byte arrives,
// and malformed or unfinished sequences produce nothing.
// Throughput: one byte per cycle while the job queue has room. A surrogate
// pair leaves as two code units, absorbed by a four-entry job queue between
// the byte front end and the output stage, so a stream of bytes is never
// slowed below one per cycle while the receiver keeps up.
// The edge that accepts a byte writes its job into the queue; from the queue
// head the unit is then loaded into the output register, from which the
// receiver can take it.
// When the receiver stalls, the output register holds its unit, the queue
// fills, and in_byte_i.ready drops once the queue is full.
// Reset clears the open sequence, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  u8u16_byte_if.sink    in_byte_i,
  u8u16_unit_if.source  out_unit_o
);
  import u8u16_pkg::*;

  logic push_valid, push_ready;
  job_t push_data;
  logic head_valid, head_pop;
  job_t head_data;

  u8u16_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  u8u16_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (head_valid),
    .pop_data_o   (head_data),
    .pop_ready_i  (head_pop)
  );

  u8u16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_data),
    .pop_o        (head_pop),
    .out_unit_o   (out_unit_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  u8u16_byte_if.sink         in_byte_i,
  output logic               push_valid_o,
  output u8u16_pkg::job_t    push_data_o,
  input  wire logic          push_ready_i
);
  import u8u16_pkg::*;

  // Bytes that follow a lead byte: 1, 2 or 3.
  function automatic logic [1:0] follow_count(input logic [7:0] lead);
    logic [1:0] cnt;
    if (lead < Lead3Min) begin
      cnt = 2'd1;
    end else if (lead < Lead4Min) begin
      cnt = 2'd2;
    end else begin
      cnt = 2'd3;
    end
    return cnt;
  endfunction

  function automatic logic is_cont(input logic [7:0] x);
    return x[7:6] == 2'b10;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] c2);
    logic ok;
    if (lead == LeadE0) begin
      ok = (c2 >= E0Min) && (c2 <= ContMax);
    end else if (lead == LeadED) begin
      ok = (c2 >= ContMin) && (c2 <= EDMax);
    end else if (lead == LeadF0) begin
      ok = (c2 >= F0Min) && (c2 <= ContMax);
    end else if (lead == LeadF4) begin
      ok = (c2 >= ContMin) && (c2 <= F4Max);
    end else begin
      ok = is_cont(c2);
    end
    return ok;
  endfunction

  logic [7:0]  lead_q, lead_d;
  logic [7:0]  second_q, second_d;
  logic [7:0]  third_q, third_d;
  logic [1:0]  pending_q, pending_d;
  logic [1:0]  lead_follow;
  logic        accept;
  logic [7:0]  cur_byte;
  logic        fin_emit;
  job_t        fin_job;
  logic [20:0] code_point;
  logic [20:0] supp_offset;
  logic        emit;
  job_t        job;

  assign in_byte_i.ready = push_ready_i;
  assign accept          = in_byte_i.valid && push_ready_i;
  assign cur_byte        = in_byte_i.text_byte;
  assign lead_follow     = follow_count(lead_q);

  // Assemble and check the sequence that the current byte completes.
  assign code_point  = {lead_q[2:0], second_q[5:0], third_q[5:0], cur_byte[5:0]};
  assign supp_offset = code_point - SuppBase;

  always_comb begin
    fin_emit = 1'b0;
    fin_job  = '0;
    unique case (lead_follow)
      2'd1: begin
        fin_emit       = is_cont(cur_byte);
        fin_job.unit_a = {5'd0, lead_q[4:0], cur_byte[5:0]};
      end
      2'd2: begin
        fin_emit       = second_ok(lead_q, second_q) && is_cont(cur_byte);
        fin_job.unit_a = {lead_q[3:0], second_q[5:0], cur_byte[5:0]};
      end
      default: begin
        fin_emit       = second_ok(lead_q, second_q) && is_cont(third_q) &&
                         is_cont(cur_byte);
        fin_job.pair   = 1'b1;
        fin_job.unit_a = SurrHigh | {6'd0, supp_offset[19:10]};
        fin_job.unit_b = SurrLow | {6'd0, supp_offset[9:0]};
      end
    endcase
  end

  // Sequence tracking per accepted byte.
  always_comb begin
    lead_d    = lead_q;
    second_d  = second_q;
    third_d   = third_q;
    pending_d = pending_q;
    emit      = 1'b0;
    job       = '0;
    if (accept) begin
      priority if (pending_q == 2'd0) begin
        if (!cur_byte[7]) begin
          emit       = 1'b1;
          job.unit_a = {8'd0, cur_byte};
        end else if ((cur_byte >= LeadMin) && (cur_byte < LeadEnd)) begin
          lead_d    = cur_byte;
          pending_d = follow_count(cur_byte);
        end
      end else if (pending_q > 2'd1) begin
        if (lead_follow == pending_q) begin
          second_d = cur_byte;
        end else begin
          third_d = cur_byte;
        end
        pending_d = pending_q - 2'd1;
      end else begin
        if (lead_follow == 2'd1) begin
          second_d = cur_byte;
        end else if (lead_follow == 2'd2) begin
          third_d = cur_byte;
        end
        pending_d = 2'd0;
        emit      = fin_emit;
        job       = fin_job;
      end
      if (in_byte_i.end_of_text) begin
        pending_d = 2'd0;
      end
    end
  end

  assign push_valid_o = emit;
  assign push_data_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      second_q  <= '0;
      third_q   <= '0;
      pending_q <= '0;
    end else begin
      lead_q    <= lead_d;
      second_q  <= second_d;
      third_q   <= third_d;
      pending_q <= pending_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire u8u16_pkg::job_t  push_data_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output u8u16_pkg::job_t       pop_data_o,
  input  wire logic             pop_ready_i
);
  import u8u16_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_ready_i && pop_valid_o;

  // Job storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire u8u16_pkg::job_t  head_i,
  output logic                  pop_o,
  u8u16_unit_if.source          out_unit_o
);
  import u8u16_pkg::*;

  logic        valid_q, valid_d;
  logic        half_q, half_d;
  logic [15:0] unit_q, unit_d;
  logic        last_q, last_d;
  logic        load;

  // The output register takes a new unit when it is empty or being drained.
  assign load = !valid_q || out_unit_o.ready;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    unit_d  = unit_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        if (head_i.pair && !half_q) begin
          unit_d = head_i.unit_a;
          last_d = 1'b0;
          half_d = 1'b1;
        end else begin
          unit_d = head_i.pair ? head_i.unit_b : head_i.unit_a;
          last_d = 1'b1;
          half_d = 1'b0;
          pop_o  = 1'b1;
        end
      end
    end
  end

  assign out_unit_o.valid       = valid_q;
  assign out_unit_o.code_unit   = unit_q;
  assign out_unit_o.last_of_run = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire
